// ===== rtl/cdu_pkg.sv =====
// shared types, constants and helper functions of the calendar date unit
`default_nettype none

package cdu_pkg;

  typedef struct packed {
    logic [6:0]  day_in;
    logic [6:0]  month_in;
    logic [13:0] year_in;
  } cdu_in_t;

  typedef struct packed {
    logic        is_valid;
    logic [2:0]  weekday;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [4:0]  prev_day;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;
  } cdu_out_t;

  localparam logic [13:0] YEAR_MIN     = 14'd1800;
  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 43690
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [10:0] DAYS_4_YEARS = 11'd1461;
  localparam logic [14:0] YEAR_OFS_LO  = 15'd4800;
  localparam logic [14:0] YEAR_OFS_HI  = 15'd4900;
  localparam logic [23:0] JDN_OFS      = 24'd32075;

  localparam logic [6:0] MON_JAN = 7'd1;
  localparam logic [6:0] MON_FEB = 7'd2;
  localparam logic [6:0] MON_MAR = 7'd3;
  localparam logic [6:0] MON_APR = 7'd4;
  localparam logic [6:0] MON_MAY = 7'd5;
  localparam logic [6:0] MON_JUN = 7'd6;
  localparam logic [6:0] MON_JUL = 7'd7;
  localparam logic [6:0] MON_AUG = 7'd8;
  localparam logic [6:0] MON_SEP = 7'd9;
  localparam logic [6:0] MON_OCT = 7'd10;
  localparam logic [6:0] MON_NOV = 7'd11;
  localparam logic [6:0] MON_DEC = 7'd12;

  // days in month, 0 for a month number outside 1..12
  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:                          len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // month term of the julian day number: |367 * (m - 2 - 12a) / 12| truncated toward zero
  function automatic logic [8:0] jdn_month_term(input logic [6:0] m);
    logic [8:0] t;
    unique case (m)
      MON_JAN: t = 9'd336;
      MON_FEB: t = 9'd367;
      MON_MAR: t = 9'd30;
      MON_APR: t = 9'd61;
      MON_MAY: t = 9'd91;
      MON_JUN: t = 9'd122;
      MON_JUL: t = 9'd152;
      MON_AUG: t = 9'd183;
      MON_SEP: t = 9'd214;
      MON_OCT: t = 9'd244;
      MON_NOV: t = 9'd275;
      MON_DEC: t = 9'd305;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // residue mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] r;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
      + 6'(x[14:12]) + 6'(x[17:15]) + 6'(x[20:18]) + 6'(x[23:21]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    if (t >= 4'd14) begin
      r = 3'd0;
    end else if (t >= 4'd7) begin
      r = 3'(t - 4'd7);
    end else begin
      r = t[2:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_unit.sv =====
// calendar date unit: gregorian date check, weekday and neighbor dates
`default_nettype none

// Takes one Gregorian date per transfer and returns whether it exists (year 1800 and up,
// Gregorian leap rule), its weekday (0 Monday .. 6 Sunday, from the julian day number mod 7)
// and the next and previous calendar dates; all fields but is_valid are 0 for a bad date.
// Three register stages, each handing off with its own valid bit: a date enters every cycle
// while the output side keeps taking transfers. Stage one forms the year offsets and the
// divide-by-100 product, stage two resolves leap year, month length and the neighbor dates,
// stage three sums the julian day number and reduces it mod 7. A stall at the output backs
// up only as far as the first empty stage.
module calendar_date_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire cdu_pkg::cdu_in_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output cdu_pkg::cdu_out_t  out_data
);
  import cdu_pkg::*;

  // stage valid bits and per-stage ready
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---------------- stage 1 ----------------
  logic [6:0]  s1_day_r, s1_month_r;
  logic [13:0] s1_year_r;
  logic [14:0] s1_yp_r, s1_xp_r;
  logic [26:0] s1_prod_y_r;

  logic        early_month;
  logic [14:0] yp_nxt, xp_nxt;
  logic [26:0] prod_y_nxt;

  always_comb begin
    early_month = (in_data.month_in <= MON_FEB);
    // subtract one year for january and february
    yp_nxt      = 15'(in_data.year_in) + YEAR_OFS_LO - 15'(early_month);
    xp_nxt      = 15'(in_data.year_in) + YEAR_OFS_HI - 15'(early_month);
    prod_y_nxt  = 27'(in_data.year_in) * 27'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_day_r    <= in_data.day_in;
      s1_month_r  <= in_data.month_in;
      s1_year_r   <= in_data.year_in;
      s1_yp_r     <= yp_nxt;
      s1_xp_r     <= xp_nxt;
      s1_prod_y_r <= prod_y_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  cdu_out_t    s2_res_r;
  logic [4:0]  s2_day_r;
  logic [22:0] s2_aterm_r;
  logic [8:0]  s2_bterm_r;
  logic [27:0] s2_prod_x_r;

  logic [7:0]  q100_y;
  logic [13:0] rem100;
  logic        century, leap;
  logic [4:0]  len, prev_len;
  logic [6:0]  prev_mon;
  logic        date_ok;
  cdu_out_t    res_nxt;
  logic [24:0] prod_a;
  logic [27:0] prod_x_nxt;

  always_comb begin
    q100_y   = s1_prod_y_r[RECIP_SHIFT +: 8];
    rem100   = s1_year_r - 14'(16'(q100_y) * 16'd100);
    century  = (rem100 == 14'd0);
    // divisible by 400 when divisible by 100 and the hundreds count by 4
    leap     = (s1_year_r[1:0] == 2'b00) && (!century || (q100_y[1:0] == 2'b00));
    len      = month_len(s1_month_r, leap);
    prev_mon = s1_month_r - 7'd1;
    prev_len = month_len(prev_mon, leap);
    date_ok  = (s1_year_r >= YEAR_MIN) && (len != 5'd0) && (s1_day_r != 7'd0)
            && (s1_day_r <= 7'(len));

    res_nxt          = '0;
    res_nxt.is_valid = date_ok;
    if (date_ok) begin
      if (s1_day_r == 7'(len)) begin
        res_nxt.next_day = 5'd1;
        if (s1_month_r == MON_DEC) begin
          res_nxt.next_month = 4'(MON_JAN);
          res_nxt.next_year  = s1_year_r + 14'd1;
        end else begin
          res_nxt.next_month = 4'(s1_month_r + 7'd1);
          res_nxt.next_year  = s1_year_r;
        end
      end else begin
        res_nxt.next_day   = 5'(s1_day_r + 7'd1);
        res_nxt.next_month = 4'(s1_month_r);
        res_nxt.next_year  = s1_year_r;
      end

      if (s1_day_r == 7'd1) begin
        if (s1_month_r == MON_JAN) begin
          res_nxt.prev_day   = 5'd31;
          res_nxt.prev_month = 4'(MON_DEC);
          res_nxt.prev_year  = s1_year_r - 14'd1;
        end else begin
          res_nxt.prev_day   = prev_len;
          res_nxt.prev_month = 4'(prev_mon);
          res_nxt.prev_year  = s1_year_r;
        end
      end else begin
        res_nxt.prev_day   = 5'(s1_day_r - 7'd1);
        res_nxt.prev_month = 4'(s1_month_r);
        res_nxt.prev_year  = s1_year_r;
      end
    end

    prod_a     = 25'(s1_yp_r) * 25'(DAYS_4_YEARS);
    prod_x_nxt = 28'(s1_xp_r) * 28'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      s2_res_r    <= res_nxt;
      s2_day_r    <= s1_day_r[4:0];
      s2_aterm_r  <= prod_a[24:2];
      s2_bterm_r  <= jdn_month_term(s1_month_r);
      s2_prod_x_r <= prod_x_nxt;
    end
  end

  // ---------------- stage 3 ----------------
  cdu_out_t   s3_res_r;

  logic [7:0] q100_x;
  logic [9:0] c3;
  logic [23:0] jdn;
  cdu_out_t   out_nxt;

  always_comb begin
    q100_x  = s2_prod_x_r[RECIP_SHIFT +: 8];
    c3      = 10'(q100_x) * 10'd3;
    jdn     = 24'(s2_aterm_r) + 24'(s2_bterm_r) + 24'(s2_day_r)
            - 24'(c3[9:2]) - JDN_OFS;
    out_nxt = s2_res_r;
    out_nxt.weekday = s2_res_r.is_valid ? mod7(jdn) : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      s3_res_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_res_r;

  // ---------------- checks ----------------
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_valid |->
      out_data.weekday == 3'd0 && out_data.next_day == 5'd0 && out_data.next_month == 4'd0 &&
      out_data.next_year == 14'd0 && out_data.prev_day == 5'd0 &&
      out_data.prev_month == 4'd0 && out_data.prev_year == 14'd0)
    else $error("invalid date carries nonzero result fields");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_valid |-> out_data.weekday <= 3'd6)
    else $error("weekday out of range");

  a_neighbor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_valid |->
      out_data.next_day != 5'd0 && out_data.prev_day != 5'd0 &&
      out_data.next_month != 4'd0 && out_data.next_month <= 4'd12 &&
      out_data.prev_month != 4'd0 && out_data.prev_month <= 4'd12)
    else $error("neighbor date out of range");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy2 |=> v2_r && $stable(s2_res_r))
    else $error("stage two dropped or changed a held item");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy1 |=> v1_r && $stable(s1_year_r))
    else $error("stage one dropped or changed a held item");

endmodule

`default_nettype wire
